[hw/rtl/vtir_pkg.sv]
// Shared types and register map constants for the VIA timer and interrupt block.
package vtir_pkg;

    // Word operation codes
    typedef logic [1:0] op_t;
    localparam op_t OP_TICK  = 2'd0;
    localparam op_t OP_READ  = 2'd1;
    localparam op_t OP_WRITE = 2'd2;

    // Register select codes
    typedef logic [3:0] addr_t;
    localparam addr_t ADDR_DDRB = 4'd2;
    localparam addr_t ADDR_DDRA = 4'd3;
    localparam addr_t ADDR_T1CL = 4'd4;
    localparam addr_t ADDR_T1CH = 4'd5;
    localparam addr_t ADDR_T1LL = 4'd6;
    localparam addr_t ADDR_T1LH = 4'd7;
    localparam addr_t ADDR_T2CL = 4'd8;
    localparam addr_t ADDR_T2CH = 4'd9;
    localparam addr_t ADDR_IFR  = 4'd13;
    localparam addr_t ADDR_IER  = 4'd14;

    // Interrupt flag positions and widths
    localparam int FLAG_W      = 7;
    localparam int FLAG_T1_BIT = 6;
    localparam int FLAG_T2_BIT = 5;
    localparam int CNT_W       = 16;

    typedef logic [FLAG_W-1:0] flags_t;
    typedef logic [CNT_W-1:0]  count_t;

    // One incoming word
    typedef struct packed {
        op_t        op;
        addr_t      addr;
        logic [7:0] value;
    } req_t;

    // One outgoing word
    typedef struct packed {
        logic [7:0] rd_value;
        logic       irq;
    } res_t;

endpackage

[hw/rtl/vtir_regs.sv]
// Timer counters, latches, direction, flag and enable registers with step logic.
module vtir_regs
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            step_en,
    input  vtir_pkg::req_t  req,
    output vtir_pkg::res_t  res
);

    vtir_pkg::count_t count1_reg, count1_next;
    vtir_pkg::count_t latch1_reg, latch1_next;
    vtir_pkg::count_t count2_reg, count2_next;
    vtir_pkg::count_t latch2_reg, latch2_next;
    logic [7:0]       ddra_reg, ddra_next;
    logic [7:0]       ddrb_reg, ddrb_next;
    vtir_pkg::flags_t flag_reg, flag_next;
    vtir_pkg::flags_t enable_reg, enable_next;
    logic [7:0]       rd_data;

    // Work out the state after this word and the byte read
    always_comb
    begin
        count1_next = count1_reg;
        latch1_next = latch1_reg;
        count2_next = count2_reg;
        latch2_next = latch2_reg;
        ddra_next   = ddra_reg;
        ddrb_next   = ddrb_reg;
        flag_next   = flag_reg;
        enable_next = enable_reg;
        rd_data     = 8'd0;

        unique case (req.op)
            vtir_pkg::OP_TICK:
            begin
                // Count down, flag on the step from one to zero, hold at zero
                if (count1_reg != '0)
                begin
                    count1_next = count1_reg - vtir_pkg::count_t'(1);
                    if (count1_reg == vtir_pkg::count_t'(1))
                        flag_next[vtir_pkg::FLAG_T1_BIT] = 1'b1;
                end
                if (count2_reg != '0)
                begin
                    count2_next = count2_reg - vtir_pkg::count_t'(1);
                    if (count2_reg == vtir_pkg::count_t'(1))
                        flag_next[vtir_pkg::FLAG_T2_BIT] = 1'b1;
                end
            end
            vtir_pkg::OP_READ:
            begin
                unique case (req.addr)
                    vtir_pkg::ADDR_DDRB: rd_data = ddrb_reg;
                    vtir_pkg::ADDR_DDRA: rd_data = ddra_reg;
                    vtir_pkg::ADDR_T1CL:
                    begin
                        rd_data = count1_reg[7:0];
                        flag_next[vtir_pkg::FLAG_T1_BIT] = 1'b0;
                    end
                    vtir_pkg::ADDR_T1CH: rd_data = count1_reg[15:8];
                    vtir_pkg::ADDR_T1LL: rd_data = latch1_reg[7:0];
                    vtir_pkg::ADDR_T1LH: rd_data = latch1_reg[15:8];
                    vtir_pkg::ADDR_T2CL:
                    begin
                        rd_data = count2_reg[7:0];
                        flag_next[vtir_pkg::FLAG_T2_BIT] = 1'b0;
                    end
                    vtir_pkg::ADDR_T2CH: rd_data = count2_reg[15:8];
                    vtir_pkg::ADDR_IFR:  rd_data = {|(flag_reg & enable_reg), flag_reg};
                    vtir_pkg::ADDR_IER:  rd_data = {1'b1, enable_reg};
                    default:             rd_data = 8'd0;
                endcase
            end
            vtir_pkg::OP_WRITE:
            begin
                unique case (req.addr) inside
                    vtir_pkg::ADDR_DDRB: ddrb_next = req.value;
                    vtir_pkg::ADDR_DDRA: ddra_next = req.value;
                    vtir_pkg::ADDR_T1CL, vtir_pkg::ADDR_T1LL:
                        latch1_next = {latch1_reg[15:8], req.value};
                    vtir_pkg::ADDR_T1CH:
                    begin
                        // Load the counter from the updated latch and rearm
                        latch1_next = {req.value, latch1_reg[7:0]};
                        count1_next = {req.value, latch1_reg[7:0]};
                        flag_next[vtir_pkg::FLAG_T1_BIT] = 1'b0;
                    end
                    vtir_pkg::ADDR_T1LH:
                        latch1_next = {req.value, latch1_reg[7:0]};
                    vtir_pkg::ADDR_T2CL:
                        latch2_next = {latch2_reg[15:8], req.value};
                    vtir_pkg::ADDR_T2CH:
                    begin
                        latch2_next = {req.value, latch2_reg[7:0]};
                        count2_next = {req.value, latch2_reg[7:0]};
                        flag_next[vtir_pkg::FLAG_T2_BIT] = 1'b0;
                    end
                    vtir_pkg::ADDR_IFR:
                        flag_next = flag_reg & ~req.value[6:0];
                    vtir_pkg::ADDR_IER:
                    begin
                        if (req.value[7])
                            enable_next = enable_reg | req.value[6:0];
                        else
                            enable_next = enable_reg & ~req.value[6:0];
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
    end

    // Read byte comes from the state before this step, irq from the state after it
    assign res.rd_value = rd_data;
    assign res.irq      = |(flag_next & enable_next);

    // Commit state when the word is processed
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count1_reg <= '0;
            latch1_reg <= '0;
            count2_reg <= '0;
            latch2_reg <= '0;
            ddra_reg   <= '0;
            ddrb_reg   <= '0;
            flag_reg   <= '0;
            enable_reg <= '0;
        end
        else if (step_en)
        begin
            count1_reg <= count1_next;
            latch1_reg <= latch1_next;
            count2_reg <= count2_next;
            latch2_reg <= latch2_next;
            ddra_reg   <= ddra_next;
            ddrb_reg   <= ddrb_next;
            flag_reg   <= flag_next;
            enable_reg <= enable_next;
        end
    end

    // Timer one high byte write rearms: flag is clear afterwards
    a_t1_rearm: assert property (@(posedge clk) disable iff (!rst_n)
        step_en && req.op == vtir_pkg::OP_WRITE && req.addr == vtir_pkg::ADDR_T1CH
        |=> !flag_reg[vtir_pkg::FLAG_T1_BIT])
        else $error("timer one flag set after rearm");

    // Expiring tick sets the timer one flag and stops the counter
    a_t1_expire: assert property (@(posedge clk) disable iff (!rst_n)
        step_en && req.op == vtir_pkg::OP_TICK && count1_reg == vtir_pkg::count_t'(1)
        |=> flag_reg[vtir_pkg::FLAG_T1_BIT] && count1_reg == '0)
        else $error("timer one expiry missed");

    // Stopped counter stays at zero on a tick
    a_t2_hold: assert property (@(posedge clk) disable iff (!rst_n)
        step_en && req.op == vtir_pkg::OP_TICK && count2_reg == '0
        |=> count2_reg == '0)
        else $error("timer two left zero on tick");

    // No word processed, no state change
    a_idle_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !step_en |=> $stable(flag_reg) && $stable(count1_reg) && $stable(count2_reg))
        else $error("state changed without a word");

endmodule

[hw/rtl/via_timer_interrupt_registers.sv]
// Top level of the VIA timer and interrupt block: input and result stages.
//
// Usage: each word on the item channel is one tick (op 0), a register read
// (op 1) or a register write (op 2) at reg_addr with data wr_value; op 3
// does nothing. Every word gives exactly one result word on the result
// channel: rd_value holds the byte read (zero for ticks, writes and op 3)
// and irq the interrupt line after the word has taken effect.
// Both channels use valid/ready; a word moves when valid and ready are high.
// Path: an accepted word passes through the input register, then the
// decode and counter logic, then the result register.
// Throughput: one word per cycle while the result side does not stall, set
// by the single pass of decode and counter logic between the input register and the result register.
// Stall: while result_ready is low the result word holds; the input register
// still takes one more word, then item_ready drops until the result drains.
// Reset: rst_n clears both counters and latches, the direction, flag and
// enable registers, and empties both stages.
module via_timer_interrupt_registers
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       item_valid,
    output logic       item_ready,
    input  logic [1:0] op,
    input  logic [3:0] reg_addr,
    input  logic [7:0] wr_value,
    output logic       result_valid,
    input  logic       result_ready,
    output logic [7:0] rd_value,
    output logic       irq
);

    logic            req_valid_reg;
    vtir_pkg::req_t  req_reg;
    logic            res_valid_reg;
    vtir_pkg::res_t  res_reg;
    vtir_pkg::res_t  step_res;
    logic            step_en;

    // Advance the held word when the result stage is free or draining
    assign step_en    = req_valid_reg && (!res_valid_reg || result_ready);
    assign item_ready = !req_valid_reg || step_en;

    // Input stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            req_valid_reg <= 1'b0;
        else if (item_ready)
            req_valid_reg <= item_valid;
    end

    always_ff @(posedge clk)
    begin
        if (item_ready && item_valid)
            req_reg <= '{op: op, addr: reg_addr, value: wr_value};
    end

    vtir_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (step_en),
        .req     (req_reg),
        .res     (step_res)
    );

    // Result stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (step_en)
            res_valid_reg <= 1'b1;
        else if (result_ready)
            res_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (step_en)
            res_reg <= step_res;
    end

    assign result_valid = res_valid_reg;
    assign rd_value     = res_reg.rd_value;
    assign irq          = res_reg.irq;

endmodule

[dv/via_timer_irq_checker.sv]
// Checker for the VIA timer and interrupt block: predicts every result word and compares it.
module via_timer_irq_checker
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       item_valid,
    input  logic       item_ready,
    input  logic [1:0] op,
    input  logic [3:0] reg_addr,
    input  logic [7:0] wr_value,
    input  logic       result_valid,
    input  logic       result_ready,
    input  logic [7:0] rd_value,
    input  logic       irq,
    output int         mismatches,
    output int         outstanding
);

    // Shadow copy of the register file
    vtir_pkg::count_t t1_count;
    vtir_pkg::count_t t1_latch;
    vtir_pkg::count_t t2_count;
    vtir_pkg::count_t t2_latch;
    logic [7:0]       dir_a;
    logic [7:0]       dir_b;
    vtir_pkg::flags_t timer_flags;
    vtir_pkg::flags_t irq_enables;

    // Result words still owed by the block, oldest first
    vtir_pkg::res_t due_results[$];

    // Apply one bus word to the shadow registers and return the word it yields
    function automatic vtir_pkg::res_t apply_bus_word(input vtir_pkg::op_t word_op,
                                                      input vtir_pkg::addr_t word_addr,
                                                      input logic [7:0] word_value);
        vtir_pkg::res_t word;
        logic [7:0]     rd;
        rd = 8'h00;
        case (word_op)
            vtir_pkg::OP_TICK:
            begin
                // Count down, flag on the step from one to zero, hold at zero
                if (t1_count == vtir_pkg::count_t'(1))
                    timer_flags[vtir_pkg::FLAG_T1_BIT] = 1'b1;
                if (t1_count != '0)
                    t1_count = t1_count - vtir_pkg::count_t'(1);
                if (t2_count == vtir_pkg::count_t'(1))
                    timer_flags[vtir_pkg::FLAG_T2_BIT] = 1'b1;
                if (t2_count != '0)
                    t2_count = t2_count - vtir_pkg::count_t'(1);
            end
            vtir_pkg::OP_READ:
            begin
                case (word_addr)
                    vtir_pkg::ADDR_DDRB: rd = dir_b;
                    vtir_pkg::ADDR_DDRA: rd = dir_a;
                    vtir_pkg::ADDR_T1CL:
                    begin
                        rd = t1_count[7:0];
                        timer_flags[vtir_pkg::FLAG_T1_BIT] = 1'b0;
                    end
                    vtir_pkg::ADDR_T1CH: rd = t1_count[15:8];
                    vtir_pkg::ADDR_T1LL: rd = t1_latch[7:0];
                    vtir_pkg::ADDR_T1LH: rd = t1_latch[15:8];
                    vtir_pkg::ADDR_T2CL:
                    begin
                        rd = t2_count[7:0];
                        timer_flags[vtir_pkg::FLAG_T2_BIT] = 1'b0;
                    end
                    vtir_pkg::ADDR_T2CH: rd = t2_count[15:8];
                    vtir_pkg::ADDR_IFR:  rd = {|(timer_flags & irq_enables), timer_flags};
                    vtir_pkg::ADDR_IER:  rd = {1'b1, irq_enables};
                    default:             rd = 8'h00;
                endcase
            end
            vtir_pkg::OP_WRITE:
            begin
                case (word_addr)
                    vtir_pkg::ADDR_DDRB: dir_b = word_value;
                    vtir_pkg::ADDR_DDRA: dir_a = word_value;
                    vtir_pkg::ADDR_T1CL, vtir_pkg::ADDR_T1LL: t1_latch[7:0] = word_value;
                    vtir_pkg::ADDR_T1CH:
                    begin
                        // Load the counter from the full latch and drop its flag
                        t1_latch[15:8] = word_value;
                        t1_count = t1_latch;
                        timer_flags[vtir_pkg::FLAG_T1_BIT] = 1'b0;
                    end
                    vtir_pkg::ADDR_T1LH: t1_latch[15:8] = word_value;
                    vtir_pkg::ADDR_T2CL: t2_latch[7:0] = word_value;
                    vtir_pkg::ADDR_T2CH:
                    begin
                        t2_latch[15:8] = word_value;
                        t2_count = t2_latch;
                        timer_flags[vtir_pkg::FLAG_T2_BIT] = 1'b0;
                    end
                    vtir_pkg::ADDR_IFR:
                        timer_flags = timer_flags & ~word_value[vtir_pkg::FLAG_W-1:0];
                    vtir_pkg::ADDR_IER:
                    begin
                        // Bit 7 picks set or clear for the selected enables
                        if (word_value[7])
                            irq_enables = irq_enables | word_value[vtir_pkg::FLAG_W-1:0];
                        else
                            irq_enables = irq_enables & ~word_value[vtir_pkg::FLAG_W-1:0];
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
        word.rd_value = rd;
        word.irq      = |(timer_flags & irq_enables);
        return word;
    endfunction

    // Retire result words, then queue the prediction for a new bus word
    always @(posedge clk or negedge rst_n)
    begin
        vtir_pkg::res_t want;
        if (!rst_n)
        begin
            t1_count    = '0;
            t1_latch    = '0;
            t2_count    = '0;
            t2_latch    = '0;
            dir_a       = '0;
            dir_b       = '0;
            timer_flags = '0;
            irq_enables = '0;
            due_results.delete();
            mismatches  = 0;
            outstanding = 0;
        end
        else
        begin
            if (result_valid && result_ready)
            begin
                if (due_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: unexpected result word rd_value=%02h irq=%b",
                                 $realtime, rd_value, irq);
                end
                else
                begin
                    want = due_results.pop_front();
                    if (rd_value !== want.rd_value || irq !== want.irq)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("%0t: mismatch rd_value exp %02h got %02h, %s %b got %b",
                                     $realtime, want.rd_value, rd_value, "irq exp",
                                     want.irq, irq);
                    end
                end
            end
            if (item_valid && item_ready)
                due_results.push_back(apply_bus_word(vtir_pkg::op_t'(op),
                                                     vtir_pkg::addr_t'(reg_addr), wr_value));
            outstanding = due_results.size();
        end
    end

endmodule

[dv/tb.sv]
// Top of the VIA timer and interrupt testbench: clock, reset, bus word stimulus and verdict.
module tb;

    // Codes the package leaves unnamed
    localparam vtir_pkg::op_t   OP_NONE   = 2'd3;
    localparam vtir_pkg::addr_t ADDR_PORT = 4'd0;
    localparam vtir_pkg::addr_t ADDR_PCR  = 4'd12;
    localparam vtir_pkg::addr_t ADDR_ORNH = 4'd15;

    localparam int TOTAL_WORDS = 1730;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       item_valid;
    logic       item_ready;
    logic [1:0] op;
    logic [3:0] reg_addr;
    logic [7:0] wr_value;
    logic       result_valid;
    logic       result_ready;
    logic [7:0] rd_value;
    logic       irq;

    int mismatches;
    int outstanding;
    int words_sent = 0;
    bit tx_calm = 1'b0;
    bit rx_calm = 1'b0;
    int hold_left = 0;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    via_timer_interrupt_registers dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .op           (op),
        .reg_addr     (reg_addr),
        .wr_value     (wr_value),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .rd_value     (rd_value),
        .irq          (irq)
    );

    via_timer_irq_checker checker_i
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .op           (op),
        .reg_addr     (reg_addr),
        .wr_value     (wr_value),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .rd_value     (rd_value),
        .irq          (irq),
        .mismatches   (mismatches),
        .outstanding  (outstanding)
    );

    // Stall the result side for a random number of cycles after each word
    always @(posedge clk)
    begin
        logic next_ready;
        next_ready = 1'b1;
        if (result_valid && result_ready)
            hold_left = rx_calm ? 0 : $urandom_range(0, 8);
        if (hold_left > 0)
        begin
            next_ready = 1'b0;
            hold_left--;
        end
        result_ready <= next_ready;
    end

    // Present one bus word after a random gap and hold it until accepted
    task automatic send_word(input vtir_pkg::op_t word_op, input vtir_pkg::addr_t word_addr,
                             input logic [7:0] word_value);
        int gap;
        gap = tx_calm ? 0 : $urandom_range(0, 8);
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        op         <= word_op;
        reg_addr   <= word_addr;
        wr_value   <= word_value;
        item_valid <= 1'b1;
        do
            @(posedge clk);
        while (!item_ready);
        words_sent++;
    endtask

    // Drop valid and hold off until every owed result word is back
    task automatic wait_drained();
        item_valid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
    endtask

    // Load a timer with a mostly short count, then run ticks over it
    task automatic arm_timer();
        logic [7:0] lo;
        logic [7:0] hi;
        int         ticks;
        lo = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) : 8'($urandom_range(0, 24));
        hi = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255)) : 8'h00;
        if ($urandom_range(0, 1) == 1)
        begin
            send_word(vtir_pkg::OP_WRITE,
                      ($urandom_range(0, 1) == 1) ? vtir_pkg::ADDR_T1CL : vtir_pkg::ADDR_T1LL,
                      lo);
            send_word(vtir_pkg::OP_WRITE, vtir_pkg::ADDR_T1CH, hi);
        end
        else
        begin
            send_word(vtir_pkg::OP_WRITE, vtir_pkg::ADDR_T2CL, lo);
            send_word(vtir_pkg::OP_WRITE, vtir_pkg::ADDR_T2CH, hi);
        end
        ticks = $urandom_range(1, 30);
        repeat (ticks)
            send_word(vtir_pkg::OP_TICK, vtir_pkg::addr_t'($urandom_range(0, 15)),
                      8'($urandom_range(0, 255)));
    endtask

    // Read a mapped register most of the time, any address otherwise
    function automatic vtir_pkg::addr_t pick_reg();
        case ($urandom_range(0, 11))
            0:       return vtir_pkg::ADDR_DDRB;
            1:       return vtir_pkg::ADDR_DDRA;
            2:       return vtir_pkg::ADDR_T1CL;
            3:       return vtir_pkg::ADDR_T1CH;
            4:       return vtir_pkg::ADDR_T1LL;
            5:       return vtir_pkg::ADDR_T1LH;
            6:       return vtir_pkg::ADDR_T2CL;
            7:       return vtir_pkg::ADDR_T2CH;
            8, 9:    return vtir_pkg::ADDR_IFR;
            10:      return vtir_pkg::ADDR_IER;
            default: return vtir_pkg::addr_t'($urandom_range(0, 15));
        endcase
    endfunction

    // Any word at all, the unused op now and then
    task automatic send_noise();
        vtir_pkg::op_t o;
        o = ($urandom_range(0, 15) == 0) ? OP_NONE : vtir_pkg::op_t'($urandom_range(0, 2));
        send_word(o, vtir_pkg::addr_t'($urandom_range(0, 15)), 8'($urandom_range(0, 255)));
    endtask

    initial
    begin
        int last_pause;
        int burst;
        rst_n        <= 1'b0;
        item_valid   <= 1'b0;
        op           <= vtir_pkg::OP_TICK;
        reg_addr     <= '0;
        wr_value     <= '0;
        result_ready <= 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: direction registers at both extremes
        send_word(vtir_pkg::OP_WRITE, vtir_pkg::ADDR_DDRB, 8'hFF);
        send_word(vtir_pkg::OP_WRITE, vtir_pkg::ADDR_DDRA, 8'h00);
        send_word(vtir_pkg::OP_READ,  vtir_pkg::ADDR_DDRB, 8'h00);
        send_word(vtir_pkg::OP_READ,  vtir_pkg::ADDR_DDRA, 8'hFF);
        // Timer one expires, then ticks on at zero
        send_word(vtir_pkg::OP_WRITE, vtir_pkg::ADDR_IER,  8'hFF);
        send_word(vtir_pkg::OP_WRITE, vtir_pkg::ADDR_T1CL, 8'h02);
        send_word(vtir_pkg::OP_WRITE, vtir_pkg::ADDR_T1CH, 8'h00);
        send_word(vtir_pkg::OP_TICK,  ADDR_PORT,           8'h00);
        send_word(vtir_pkg::OP_TICK,  ADDR_PORT,           8'h00);
        send_word(vtir_pkg::OP_TICK,  ADDR_ORNH,           8'hFF);
        send_word(vtir_pkg::OP_READ,  vtir_pkg::ADDR_IFR,  8'h00);
        send_word(vtir_pkg::OP_READ,  vtir_pkg::ADDR_T1CL, 8'h00);
        // Timer two expires, flags cleared by writing ones
        send_word(vtir_pkg::OP_WRITE, vtir_pkg::ADDR_T2CL, 8'h01);
        send_word(vtir_pkg::OP_WRITE, vtir_pkg::ADDR_T2CH, 8'h00);
        send_word(vtir_pkg::OP_TICK,  ADDR_PORT,           8'h00);
        send_word(vtir_pkg::OP_READ,  vtir_pkg::ADDR_IFR,  8'h00);
        send_word(vtir_pkg::OP_WRITE, vtir_pkg::ADDR_IFR,  8'h7F);
        // Latch registers without a load
        send_word(vtir_pkg::OP_WRITE, vtir_pkg::ADDR_T1LL, 8'hFF);
        send_word(vtir_pkg::OP_WRITE, vtir_pkg::ADDR_T1LH, 8'hFF);
        send_word(vtir_pkg::OP_READ,  vtir_pkg::ADDR_T1LH, 8'h00);
        send_word(vtir_pkg::OP_READ,  vtir_pkg::ADDR_T1CH, 8'h00);
        send_word(vtir_pkg::OP_READ,  vtir_pkg::ADDR_T2CH, 8'h00);
        // Clear every enable, then the unmapped addresses and the unused op
        send_word(vtir_pkg::OP_WRITE, vtir_pkg::ADDR_IER,  8'h7F);
        send_word(vtir_pkg::OP_READ,  vtir_pkg::ADDR_IER,  8'h00);
        send_word(vtir_pkg::OP_WRITE, ADDR_ORNH,           8'hFF);
        send_word(vtir_pkg::OP_READ,  ADDR_ORNH,           8'h00);
        send_word(vtir_pkg::OP_WRITE, ADDR_PCR,            8'hFF);
        send_word(OP_NONE,            vtir_pkg::ADDR_IFR,  8'hFF);

        // Random: mostly timer runs with interrupt traffic around them
        last_pause = words_sent;
        while (words_sent < TOTAL_WORDS)
        begin
            if (words_sent - last_pause >= 300)
            begin
                wait_drained();
                last_pause = words_sent;
            end
            tx_calm = ($urandom_range(0, 4) == 0);
            rx_calm = ($urandom_range(0, 4) == 0);
            case ($urandom_range(0, 9))
                0, 1, 2: arm_timer();
                3:
                begin
                    send_word(vtir_pkg::OP_WRITE, vtir_pkg::ADDR_IER,
                              8'($urandom_range(0, 255)));
                    if ($urandom_range(0, 1) == 1)
                        send_word(vtir_pkg::OP_WRITE, vtir_pkg::ADDR_IFR,
                                  8'($urandom_range(0, 255)));
                end
                4, 5:
                begin
                    burst = $urandom_range(1, 3);
                    repeat (burst)
                        send_word(vtir_pkg::OP_READ, pick_reg(), 8'($urandom_range(0, 255)));
                end
                6, 7:
                begin
                    burst = $urandom_range(1, 4);
                    repeat (burst)
                        send_noise();
                end
                default:
                begin
                    burst = $urandom_range(1, 10);
                    repeat (burst)
                        send_word(vtir_pkg::OP_TICK, pick_reg(), 8'($urandom_range(0, 255)));
                end
            endcase
        end

        // Drain and let the pipeline settle
        wait_drained();
        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // Give up on a hung handshake
    initial
    begin
        #5000000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
